// ===== rtl/sorted_table_binary_search_defines.svh =====
// Assertion helpers for the block's top-level file.
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STBS_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define STBS_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

// ===== rtl/stbs_pkg.sv =====
package stbs_pkg;

   localparam int DEPTH  = 256;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int MODE_W = 2;
   localparam int POS_W  = 8;
   localparam int ENT_W  = 9;

   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_PROBE = 4'b0010,
      S_CMP   = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] wdata;
   } mem_req_type;

   typedef struct packed {
      logic [CNT_W-1:0] fill;
      logic             comparing;
      logic             idle;
   } seq_stat_type;

endpackage

// ===== rtl/stbs_req_if.sv =====
interface stbs_req_if;
   import stbs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== rtl/stbs_rsp_if.sv =====
interface stbs_rsp_if;
   import stbs_pkg::*;

   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] position;
   logic             status;
   logic [ENT_W-1:0] entries;

   modport source (output valid, output found, output position, output status,
                   output entries, input ready);
   modport sink   (input valid, input found, input position, input status,
                   input entries, output ready);
endinterface

// ===== rtl/stbs_table_ram.sv =====
module stbs_table_ram (
   input  logic                        clock,
   input  stbs_pkg::mem_req_type       mem_req,
   output logic [stbs_pkg::DATA_W-1:0] rd_data
);
   import stbs_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= mem[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/stbs_search_seq.sv =====
module stbs_search_seq (
   input  logic                        clock,
   input  logic                        reset,
   stbs_req_if.sink                    req_chan,
   stbs_rsp_if.source                  rsp_chan,
   output stbs_pkg::mem_req_type       mem_req,
   input  logic [stbs_pkg::DATA_W-1:0] rd_data,
   output stbs_pkg::seq_stat_type      seq_stat
);
   import stbs_pkg::*;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [CNT_W-1:0]         lo_ff, lo_in;
   logic [CNT_W-1:0]         hx_ff, hx_in;
   logic [IDX_W-1:0]         mid_ff, mid_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic                     res_found_ff, res_found_in;
   logic [IDX_W-1:0]         res_pos_ff, res_pos_in;
   logic                     res_status_ff, res_status_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     out_found_ff, out_found_in;
   logic [POS_W-1:0]         out_pos_ff, out_pos_in;
   logic                     out_status_ff, out_status_in;
   logic [ENT_W-1:0]         out_entries_ff, out_entries_in;

   logic [CNT_W-1:0]         span;
   logic [CNT_W-1:0]         mid_full;
   logic                     probe_live;
   logic signed [DATA_W-1:0] entry;

   // hx holds hi + 1 of the closed interval, so mid = lo + (hi - lo) / 2
   assign span       = hx_ff - lo_ff - CNT_W'(1);
   assign mid_full   = lo_ff + (span >> 1);
   assign probe_live = (lo_ff < hx_ff);
   assign entry      = $signed(rd_data);

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      lo_in          = lo_ff;
      hx_in          = hx_ff;
      mid_in         = mid_ff;
      key_in         = key_ff;
      res_found_in   = res_found_ff;
      res_pos_in     = res_pos_ff;
      res_status_in  = res_status_ff;
      out_valid_in   = out_valid_ff;
      out_found_in   = out_found_ff;
      out_pos_in     = out_pos_ff;
      out_status_in  = out_status_ff;
      out_entries_in = out_entries_ff;
      mem_req.we     = 1'b0;
      mem_req.re     = 1'b0;
      mem_req.addr   = mid_full[IDX_W-1:0];
      mem_req.wdata  = req_chan.value;

      // drop the output word once taken
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               key_in        = req_chan.value;
               res_found_in  = 1'b0;
               res_pos_in    = '0;
               res_status_in = 1'b0;
               state_in      = S_DONE;
               case (req_chan.mode)
                  MODE_LOAD: begin
                     if (fill_ff < CNT_W'(DEPTH)) begin
                        mem_req.we   = 1'b1;
                        mem_req.addr = fill_ff[IDX_W-1:0];
                        fill_in      = fill_ff + CNT_W'(1);
                     end else begin
                        res_status_in = 1'b1;
                     end
                  end
                  MODE_SEARCH: begin
                     lo_in    = '0;
                     hx_in    = fill_ff;
                     state_in = S_PROBE;
                  end
                  MODE_CLEAR: begin
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PROBE: begin
            if (probe_live) begin
               mem_req.re = 1'b1;
               mid_in     = mid_full[IDX_W-1:0];
               state_in   = S_CMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CMP: begin
            if (entry == key_ff) begin
               res_found_in = 1'b1;
               res_pos_in   = mid_ff;
               state_in     = S_DONE;
            end else begin
               if (entry > key_ff) begin
                  hx_in = CNT_W'(mid_ff);
               end else begin
                  lo_in = CNT_W'(mid_ff) + CNT_W'(1);
               end
               state_in = S_PROBE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in   = 1'b1;
               out_found_in   = res_found_ff;
               out_pos_in     = POS_W'(res_pos_ff);
               out_status_in  = res_status_ff;
               out_entries_in = ENT_W'(fill_ff);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      hx_ff          <= hx_in;
      mid_ff         <= mid_in;
      key_ff         <= key_in;
      res_found_ff   <= res_found_in;
      res_pos_ff     <= res_pos_in;
      res_status_ff  <= res_status_in;
      out_found_ff   <= out_found_in;
      out_pos_ff     <= out_pos_in;
      out_status_ff  <= out_status_in;
      out_entries_ff <= out_entries_in;
   end

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.found    = out_found_ff;
   assign rsp_chan.position = out_pos_ff;
   assign rsp_chan.status   = out_status_ff;
   assign rsp_chan.entries  = out_entries_ff;

   assign seq_stat.fill      = fill_ff;
   assign seq_stat.comparing = (state_ff == S_CMP);
   assign seq_stat.idle      = (state_ff == S_IDLE);
endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// Sorted table with binary search lookup.
// req_chan carries one word per item: mode (load, search, clear) and a signed
// 32-bit value. rsp_chan returns exactly one word per item: found, position,
// status (1 = load dropped, table full) and the entry count after the item.
// Load software entries in ascending order; a search halves the closed range
// of loaded entries and reports the first probed index that matches.
// One item is in work at a time: req_chan.ready is high only when idle.
// Load, clear and unused modes go from idle to S_DONE, which writes the
// result word into the output register. A search steps S_PROBE and S_CMP
// per probe until a hit or an empty range, then S_DONE; the number of probes
// is at most log2(DEPTH) + 1. Each probe is one table read plus one compare on the
// single read port of the table RAM.
// The next item is accepted only after the current one has left S_DONE.
// The result sits in an output register, so a new item is accepted while the
// previous word waits; a finished item is held inside until that register
// frees up when rsp_chan stays stalled.
// Reset (synchronous, active high) empties the table and drops any pending
// word; table contents are not cleared, only the entry count.
module sorted_table_binary_search (
   input  logic       clock,
   input  logic       reset,
   stbs_req_if.sink   req_chan,
   stbs_rsp_if.source rsp_chan
);
   import stbs_pkg::*;
   `include "sorted_table_binary_search_defines.svh"

   mem_req_type       mem_req;
   logic [DATA_W-1:0] rd_data;
   seq_stat_type      seq_stat;

   stbs_search_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .mem_req  (mem_req),
      .rd_data  (rd_data),
      .seq_stat (seq_stat)
   );

   stbs_table_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   `STBS_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, seq_stat.fill <= CNT_W'(DEPTH))
   `STBS_ASSERT_NOW(a_write_on_load, clock, reset, mem_req.we,
      req_chan.valid && req_chan.ready && req_chan.mode == MODE_LOAD)
   `STBS_ASSERT_NEXT(a_read_then_cmp, clock, reset, mem_req.re, seq_stat.comparing)
   `STBS_ASSERT_NOW(a_ready_idle, clock, reset, mem_req.re || seq_stat.comparing,
      !req_chan.ready)
   `STBS_ASSERT_NOW(a_idle_ready, clock, reset, 1'b1, req_chan.ready == seq_stat.idle)
endmodule
